// File: src/eased_tween_interpolator_assert.svh
// Assertion macros shared by the tween interpolator RTL.
`ifndef EASED_TWEEN_INTERPOLATOR_ASSERT_SVH
`define EASED_TWEEN_INTERPOLATOR_ASSERT_SVH

// same-cycle implication, clocked by clk, off during reset
`define ETI_ASSERT_NOW(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("tween check failed");

// next-cycle implication
`define ETI_ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("tween check failed");

`endif

// File: src/tww_pkg.sv
// Shared types and constants of the tween interpolator.
package tww_pkg;

	localparam int E_MAX_W   = 26;
	localparam int NUM_PROPS = 5;
	localparam int LP_W      = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] EASE_LINEAR  = 2'd0;
	localparam logic [1:0] EASE_EXP     = 2'd1;
	localparam logic [1:0] EASE_ELASTIC = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_EASE_KIND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 2'd1;

	localparam longint Q30_ONE   = 64'sd1073741824;
	localparam longint LN2_Q30   = 64'sd744261118;
	localparam longint TWOPI_Q30 = 64'sd6746518852;

	typedef logic signed [31:0] prop_t;

	typedef struct packed {
		logic [E_MAX_W-1:0]          ease;
		logic [LP_W-1:0]             lprog;
		prop_t [NUM_PROPS-1:0]       start;
		prop_t [NUM_PROPS-1:0]       goal;
	} tween_job_t;

endpackage

// File: src/tww_front.sv
// Front end: config registers, elapsed time, progress divider and ease lookup.
module tww_front #(
	parameter int EASE_TABLE_DEPTH = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tww_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [31:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [19:0]                        delta_time_us,
	input  tww_pkg::prop_t [tww_pkg::NUM_PROPS-1:0] start,
	input  tww_pkg::prop_t [tww_pkg::NUM_PROPS-1:0] goal,
	input  logic                               job_full,
	output logic                               job_push,
	output tww_pkg::tween_job_t                job
);
	import tww_pkg::*;

	localparam int IW = (EASE_TABLE_DEPTH > 1) ? $clog2(EASE_TABLE_DEPTH) : 1;
	localparam int PW = FRAC_BITS + IW + 1;
	localparam int CW = $clog2(FRAC_BITS);
	localparam int LP_SH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 16 - FRAC_BITS;

	localparam longint TBL_DEP  = longint'(EASE_TABLE_DEPTH);
	localparam longint EL_PER   = 64'sd12 * TBL_DEP;
	localparam longint Q30_HALF = 64'sd1 <<< (29 - FRAC_BITS);
	localparam longint QTR      = 64'sd1 <<< 28;

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_LOOK, S_PUSH} state_t;

	state_t                 state_q;
	logic [1:0]             kind_q;
	logic [31:0]            dur_q;
	logic [31:0]            elapsed_q;
	logic [31:0]            rem_q;
	logic [FRAC_BITS-1:0]   quot_q;
	logic                   full_q;
	logic [CW-1:0]          cnt_q;
	prop_t [NUM_PROPS-1:0]  start_q;
	prop_t [NUM_PROPS-1:0]  goal_q;

	logic [31:0]            dur_eff;
	logic [32:0]            sum;
	logic [31:0]            elapsed_next;
	logic [32:0]            rem_sh;
	logic                   rem_ge;
	logic [FRAC_BITS:0]     p;
	logic [PW-1:0]          idx_prod;
	logic [IW-1:0]          idx;
	logic [FRAC_BITS+1:0]   ease_val;

	logic [E_MAX_W-1:0]     exp_tbl [EASE_TABLE_DEPTH];
	logic [E_MAX_W-1:0]     ela_tbl [EASE_TABLE_DEPTH];
	logic [E_MAX_W-1:0]     exp_q;
	logic [E_MAX_W-1:0]     ela_q;

	for (genvar g = 0; g < EASE_TABLE_DEPTH; g++) begin : g_tbl
		// 2^(-10t): integer part as a shift, fraction part by series
		localparam longint XA_NUM = 64'sd10 * g;
		localparam longint XA_N   = XA_NUM / TBL_DEP;
		localparam longint XA_U   = (XA_NUM % TBL_DEP) * LN2_Q30 / TBL_DEP;
		localparam longint XA_T1  = Q30_ONE * XA_U / (64'sd1 * Q30_ONE);
		localparam longint XA_T2  = XA_T1 * XA_U / (64'sd2 * Q30_ONE);
		localparam longint XA_T3  = XA_T2 * XA_U / (64'sd3 * Q30_ONE);
		localparam longint XA_T4  = XA_T3 * XA_U / (64'sd4 * Q30_ONE);
		localparam longint XA_T5  = XA_T4 * XA_U / (64'sd5 * Q30_ONE);
		localparam longint XA_T6  = XA_T5 * XA_U / (64'sd6 * Q30_ONE);
		localparam longint XA_T7  = XA_T6 * XA_U / (64'sd7 * Q30_ONE);
		localparam longint XA_T8  = XA_T7 * XA_U / (64'sd8 * Q30_ONE);
		localparam longint XA_T9  = XA_T8 * XA_U / (64'sd9 * Q30_ONE);
		localparam longint XA_T10 = XA_T9 * XA_U / (64'sd10 * Q30_ONE);
		localparam longint XA_T11 = XA_T10 * XA_U / (64'sd11 * Q30_ONE);
		localparam longint XA_T12 = XA_T11 * XA_U / (64'sd12 * Q30_ONE);
		localparam longint XA_T13 = XA_T12 * XA_U / (64'sd13 * Q30_ONE);
		localparam longint XA_T14 = XA_T13 * XA_U / (64'sd14 * Q30_ONE);
		localparam longint XA_S   = Q30_ONE - XA_T1 + XA_T2 - XA_T3 + XA_T4 - XA_T5
			+ XA_T6 - XA_T7 + XA_T8 - XA_T9 + XA_T10 - XA_T11 + XA_T12 - XA_T13 + XA_T14;
		localparam longint XA_EX  = (XA_N > 64'sd40) ? 64'sd0 : (XA_S >>> XA_N);
		localparam longint EXP_E  = Q30_ONE - XA_EX;

		// 2^(-12t) envelope of the elastic curve
		localparam longint XB_NUM = 64'sd12 * g;
		localparam longint XB_N   = XB_NUM / TBL_DEP;
		localparam longint XB_U   = (XB_NUM % TBL_DEP) * LN2_Q30 / TBL_DEP;
		localparam longint XB_T1  = Q30_ONE * XB_U / (64'sd1 * Q30_ONE);
		localparam longint XB_T2  = XB_T1 * XB_U / (64'sd2 * Q30_ONE);
		localparam longint XB_T3  = XB_T2 * XB_U / (64'sd3 * Q30_ONE);
		localparam longint XB_T4  = XB_T3 * XB_U / (64'sd4 * Q30_ONE);
		localparam longint XB_T5  = XB_T4 * XB_U / (64'sd5 * Q30_ONE);
		localparam longint XB_T6  = XB_T5 * XB_U / (64'sd6 * Q30_ONE);
		localparam longint XB_T7  = XB_T6 * XB_U / (64'sd7 * Q30_ONE);
		localparam longint XB_T8  = XB_T7 * XB_U / (64'sd8 * Q30_ONE);
		localparam longint XB_T9  = XB_T8 * XB_U / (64'sd9 * Q30_ONE);
		localparam longint XB_T10 = XB_T9 * XB_U / (64'sd10 * Q30_ONE);
		localparam longint XB_T11 = XB_T10 * XB_U / (64'sd11 * Q30_ONE);
		localparam longint XB_T12 = XB_T11 * XB_U / (64'sd12 * Q30_ONE);
		localparam longint XB_T13 = XB_T12 * XB_U / (64'sd13 * Q30_ONE);
		localparam longint XB_T14 = XB_T13 * XB_U / (64'sd14 * Q30_ONE);
		localparam longint XB_S   = Q30_ONE - XB_T1 + XB_T2 - XB_T3 + XB_T4 - XB_T5
			+ XB_T6 - XB_T7 + XB_T8 - XB_T9 + XB_T10 - XB_T11 + XB_T12 - XB_T13 + XB_T14;
		localparam longint XB_EX  = (XB_N > 64'sd40) ? 64'sd0 : (XB_S >>> XB_N);

		// sine phase in turns, quadrant folded
		localparam longint EL_M   = 64'sd32 * g - 64'sd3 * TBL_DEP;
		localparam longint EL_R   = ((EL_M % EL_PER) + EL_PER) % EL_PER;
		localparam longint EL_PH  = (EL_R <<< 30) / EL_PER;
		localparam longint SN_Q   = (EL_PH >>> 28) & 64'sd3;
		localparam longint SN_X0  = EL_PH & (QTR - 64'sd1);
		localparam longint SN_X   = ((SN_Q & 64'sd1) != 64'sd0) ? QTR - SN_X0 : SN_X0;
		localparam longint SN_A   = (SN_X * TWOPI_Q30) >>> 30;
		localparam longint SN_T1  = ((((SN_A * SN_A) >>> 30) * SN_A) >>> 30) / 64'sd6;
		localparam longint SN_T2  = ((((SN_T1 * SN_A) >>> 30) * SN_A) >>> 30) / 64'sd20;
		localparam longint SN_T3  = ((((SN_T2 * SN_A) >>> 30) * SN_A) >>> 30) / 64'sd42;
		localparam longint SN_T4  = ((((SN_T3 * SN_A) >>> 30) * SN_A) >>> 30) / 64'sd72;
		localparam longint SN_T5  = ((((SN_T4 * SN_A) >>> 30) * SN_A) >>> 30) / 64'sd110;
		localparam longint SN_T6  = ((((SN_T5 * SN_A) >>> 30) * SN_A) >>> 30) / 64'sd156;
		localparam longint SN_T7  = ((((SN_T6 * SN_A) >>> 30) * SN_A) >>> 30) / 64'sd210;
		localparam longint SN_T8  = ((((SN_T7 * SN_A) >>> 30) * SN_A) >>> 30) / 64'sd272;
		localparam longint SN_S   = SN_A - SN_T1 + SN_T2 - SN_T3 + SN_T4 - SN_T5 + SN_T6
			- SN_T7 + SN_T8;
		localparam longint SN_V   = (SN_Q >= 64'sd2) ? -SN_S : SN_S;
		localparam longint ELA_E0 = (SN_V * XB_EX) / Q30_ONE + Q30_ONE;
		localparam longint ELA_E  = (ELA_E0 < 64'sd0) ? 64'sd0 : ELA_E0;

		localparam logic [E_MAX_W-1:0] EXP_V =
			E_MAX_W'((EXP_E + Q30_HALF) >>> (30 - FRAC_BITS));
		localparam logic [E_MAX_W-1:0] ELA_V =
			E_MAX_W'((ELA_E + Q30_HALF) >>> (30 - FRAC_BITS));
		assign exp_tbl[g] = EXP_V;
		assign ela_tbl[g] = ELA_V;
	end

	assign dur_eff      = (dur_q == 32'd0) ? 32'd1 : dur_q;
	assign sum          = {1'b0, elapsed_q} + 33'(delta_time_us);
	assign elapsed_next = (sum > {1'b0, dur_eff}) ? dur_eff : sum[31:0];
	assign rem_sh       = {rem_q, 1'b0};
	assign rem_ge       = rem_sh >= {1'b0, dur_eff};
	assign p            = {full_q, quot_q};
	assign idx_prod     = PW'(p) * PW'(EASE_TABLE_DEPTH);
	assign idx          = idx_prod[FRAC_BITS +: IW];

	always_ff @(posedge clk) begin
		exp_q <= exp_tbl[idx];
		ela_q <= ela_tbl[idx];
	end

	always_comb begin
		if (kind_q != EASE_EXP && kind_q != EASE_ELASTIC)
			ease_val = (FRAC_BITS + 2)'(p);
		else if (full_q)
			ease_val = (FRAC_BITS + 2)'(p);
		else if (p == '0 && kind_q == EASE_ELASTIC)
			ease_val = '0;
		else if (kind_q == EASE_EXP)
			ease_val = exp_q[FRAC_BITS+1:0];
		else
			ease_val = ela_q[FRAC_BITS+1:0];
	end

	always_comb begin
		job.ease  = E_MAX_W'(ease_val);
		job.start = start_q;
		job.goal  = goal_q;
		if (FRAC_BITS >= 16)
			job.lprog = LP_W'(p >> LP_SH);
		else
			job.lprog = LP_W'(p) << LP_SH;
	end

	assign in_ready = (state_q == S_IDLE);
	assign job_push = (state_q == S_PUSH) && !job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			kind_q    <= EASE_LINEAR;
			dur_q     <= 32'd1000000;
			elapsed_q <= '0;
			rem_q     <= '0;
			quot_q    <= '0;
			full_q    <= 1'b0;
			cnt_q     <= '0;
			start_q   <= '0;
			goal_q    <= '0;
		end else begin
			if (cfg_we) begin
				priority case (cfg_idx)
					REG_EASE_KIND: kind_q <= cfg_data[1:0];
					REG_DURATION:  dur_q  <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						elapsed_q <= elapsed_next;
						full_q    <= (elapsed_next == dur_eff);
						rem_q     <= (elapsed_next == dur_eff) ? 32'd0 : elapsed_next;
						quot_q    <= '0;
						cnt_q     <= '0;
						start_q   <= start;
						goal_q    <= goal;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q  <= rem_ge ? 32'(rem_sh - {1'b0, dur_eff}) : rem_sh[31:0];
					quot_q <= {quot_q[FRAC_BITS-2:0], rem_ge};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CW'(FRAC_BITS - 1))
						state_q <= S_LOOK;
				end
				S_LOOK: state_q <= S_PUSH;
				S_PUSH: begin
					if (!job_full)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: src/tww_fifo.sv
// Two-entry job queue between the front and back ends.
module tww_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tww_pkg::tween_job_t wdata,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output tww_pkg::tween_job_t rdata
);
	import tww_pkg::*;

	tween_job_t  mem [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// File: src/tww_back.sv
// Back end: five lerps through one shared multiplier, then the output register.
module tww_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               job_valid,
	input  tww_pkg::tween_job_t                job,
	output logic                               job_pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output tww_pkg::prop_t [tww_pkg::NUM_PROPS-1:0] res,
	output logic [tww_pkg::LP_W-1:0]           lprog
);
	import tww_pkg::*;

	localparam int PRW = 33 + E_MAX_W + 1;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} state_t;

	state_t                   state_q;
	logic [2:0]               issue_q;
	logic                     v_s1, v_s2;
	logic [2:0]               lane_s1, lane_s2;
	tween_job_t               job_q;
	logic signed [32:0]       d_s1;
	prop_t                    a_s1, a_s2;
	logic signed [PRW-1:0]    prod_s2;
	prop_t [NUM_PROPS-1:0]    res_q;

	logic signed [E_MAX_W:0]  e_sg;
	logic signed [PRW-1:0]    rnd;
	logic signed [PRW:0]      tot;
	prop_t                    sat;

	assign e_sg    = $signed({1'b0, job_q.ease});
	assign rnd     = (prod_s2 + (PRW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	assign tot     = (PRW + 1)'(a_s2) + (PRW + 1)'(rnd);
	assign job_pop = (state_q == S_IDLE) && job_valid;
	assign res     = res_q;
	assign lprog   = job_q.lprog;

	always_comb begin
		if (tot > (PRW + 1)'(64'sd2147483647))
			sat = 32'sh7FFFFFFF;
		else if (tot < -(PRW + 1)'(64'sd2147483648))
			sat = 32'sh80000000;
		else
			sat = tot[31:0];
	end

	always_ff @(posedge clk) begin
		if (job_pop)
			job_q <= job;
		d_s1    <= 33'(job_q.goal[issue_q]) - 33'(job_q.start[issue_q]);
		a_s1    <= job_q.start[issue_q];
		prod_s2 <= PRW'(d_s1) * PRW'(e_sg);
		a_s2    <= a_s1;
		if (v_s2)
			res_q[lane_s2] <= sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			issue_q   <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			lane_s1   <= '0;
			lane_s2   <= '0;
			out_valid <= 1'b0;
		end else begin
			v_s1    <= (state_q == S_RUN) && (issue_q < 3'(NUM_PROPS));
			lane_s1 <= issue_q;
			v_s2    <= v_s1;
			lane_s2 <= lane_s1;
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						issue_q <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (issue_q < 3'(NUM_PROPS))
						issue_q <= issue_q + 3'd1;
					if (v_s2 && lane_s2 == 3'(NUM_PROPS - 1)) begin
						out_valid <= 1'b1;
						state_q   <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: src/eased_tween_interpolator.sv
// Top level of the eased tween interpolator.
// Front end: accepts a tick, runs FRAC_BITS bit-serial divider steps, reads the ease ROM, then pushes the job.
// Back end: runs the five lerps through its single shared multiplier, plus output handshake.
// The front end takes a new tick only after it has pushed the job of the last one, and it
// stalls while the job queue is full.
// Async reset: ease linear, duration 1000000 us, elapsed time zero, queue empty.
module eased_tween_interpolator #(
	parameter int EASE_TABLE_DEPTH = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tww_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [19:0]                   delta_time_us,
	input  logic signed [31:0]            start_x,
	input  logic signed [31:0]            start_y,
	input  logic signed [31:0]            start_width,
	input  logic signed [31:0]            start_height,
	input  logic signed [31:0]            start_rotation,
	input  logic signed [31:0]            goal_x,
	input  logic signed [31:0]            goal_y,
	input  logic signed [31:0]            goal_width,
	input  logic signed [31:0]            goal_height,
	input  logic signed [31:0]            goal_rotation,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            out_x,
	output logic signed [31:0]            out_y,
	output logic signed [31:0]            out_width,
	output logic signed [31:0]            out_height,
	output logic signed [31:0]            out_rotation,
	output logic [16:0]                   linear_progress
);
	import tww_pkg::*;
	`include "eased_tween_interpolator_assert.svh"

	prop_t [NUM_PROPS-1:0] start;
	prop_t [NUM_PROPS-1:0] goal;
	prop_t [NUM_PROPS-1:0] res;
	tween_job_t            push_job;
	tween_job_t            pop_job;
	logic                  push, pop, full, empty;

	assign start = {start_rotation, start_height, start_width, start_y, start_x};
	assign goal  = {goal_rotation, goal_height, goal_width, goal_y, goal_x};
	assign out_x        = res[0];
	assign out_y        = res[1];
	assign out_width    = res[2];
	assign out_height   = res[3];
	assign out_rotation = res[4];

	tww_front #(
		.EASE_TABLE_DEPTH(EASE_TABLE_DEPTH),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .delta_time_us(delta_time_us),
		.start(start), .goal(goal),
		.job_full(full), .job_push(push), .job(push_job)
	);

	tww_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(push_job), .full(full),
		.pop(pop), .empty(empty), .rdata(pop_job)
	);

	tww_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(!empty), .job(pop_job), .job_pop(pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.res(res), .lprog(linear_progress)
	);

	`ETI_ASSERT_NOW(a_no_overflow, push, !full)
	`ETI_ASSERT_NOW(a_no_underflow, pop, !empty)
	`ETI_ASSERT_NEXT(a_front_busy, in_valid && in_ready, !in_ready)

endmodule

// File: test/eased_tween_interpolator_tb.sv
// Self-checking testbench of the eased tween interpolator: predicts every tween beat and compares.
`timescale 1ns / 100ps

module eased_tween_interpolator_tb;
	import tww_pkg::*;

	localparam int  TBL_DEPTH = 1024;
	localparam int  FB        = 16;
	localparam longint ONE_E  = 64'sd1 <<< FB;
	localparam int  SETTLE    = 80;
	localparam int  WD_LIMIT  = 5000;

	typedef struct {
		logic [19:0] dt;
		prop_t       src [NUM_PROPS];
		prop_t       dst [NUM_PROPS];
	} tick_t;

	typedef struct {
		prop_t       prop [NUM_PROPS];
		logic [16:0] lprog;
	} frame_t;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [19:0] delta_time_us = '0;
	prop_t start_x = 0, start_y = 0, start_width = 0, start_height = 0, start_rotation = 0;
	prop_t goal_x = 0, goal_y = 0, goal_width = 0, goal_height = 0, goal_rotation = 0;
	prop_t out_x, out_y, out_width, out_height, out_rotation;
	logic [16:0] linear_progress;

	eased_tween_interpolator u_top (.*);

	initial forever #6 clk = ~clk;

	// tween state as predicted
	logic [1:0]  mdl_kind = EASE_LINEAR;
	logic [31:0] mdl_dur = 32'd1000000;
	logic [31:0] mdl_elapsed = '0;

	tick_t  tick_q [$];
	frame_t frame_q [$];
	tick_t  cur_tick;
	int     in_gap = 0, out_gap = 0, n_ticks = 0, n_frames = 0, n_err = 0, idle_cyc = 0;
	int     n_sat = 0, n_done = 0;
	bit     all_sent = 0;

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic longint pow2_neg(longint num, longint den);
		longint whole, frac, u, term, acc;
		whole = num / den;
		frac = num % den;
		u = frac * LN2_Q30 / den;
		term = Q30_ONE;
		acc = Q30_ONE;
		for (int k = 1; k <= 14; k++) begin
			term = term * u / (longint'(k) <<< 30);
			acc = (k % 2 == 1) ? acc - term : acc + term;
		end
		if (whole > 40) return 0;
		return acc >>> whole;
	endfunction

	function automatic longint sine_turns(longint ph);
		longint quad, x, a, term, acc, t2;
		quad = (ph >>> 28) & 3;
		x = ph & ((64'sd1 <<< 28) - 1);
		if (quad % 2 == 1) x = (64'sd1 <<< 28) - x;
		a = (x * TWOPI_Q30) >>> 30;
		term = a;
		acc = a;
		for (int k = 1; k <= 8; k++) begin
			t2 = (term * a) >>> 30;
			t2 = (t2 * a) >>> 30;
			term = t2 / (longint'(2 * k) * longint'(2 * k + 1));
			acc = (k % 2 == 1) ? acc - term : acc + term;
		end
		return (quad >= 2) ? -acc : acc;
	endfunction

	function automatic longint eased(logic [1:0] kind, longint p);
		longint idx, per, m, r, ph, s, ex, e;
		if (kind != EASE_EXP && kind != EASE_ELASTIC) return p;
		if (p >= ONE_E) return ONE_E;
		if (p <= 0 && kind == EASE_ELASTIC) return 0;
		if (p < 0) p = 0;
		idx = (p * TBL_DEPTH) >>> FB;
		if (kind == EASE_EXP) begin
			e = Q30_ONE - pow2_neg(10 * idx, TBL_DEPTH);
		end else begin
			per = 12 * TBL_DEPTH;
			m = 32 * idx - 3 * TBL_DEPTH;
			r = ((m % per) + per) % per;
			ph = (r <<< 30) / per;
			s = sine_turns(ph);
			ex = pow2_neg(12 * idx, TBL_DEPTH);
			e = (s * ex) / Q30_ONE + Q30_ONE;
			if (e < 0) e = 0;
		end
		return (e + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
	endfunction

	function automatic prop_t lerp_clip(prop_t a, prop_t b, longint e);
		longint d, v;
		d = longint'(b) - longint'(a);
		v = longint'(a) + ((d * e + (64'sd1 <<< (FB - 1))) >>> FB);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return prop_t'(v[31:0]);
	endfunction

	task automatic predict_tick(tick_t t);
		frame_t f;
		longint unsigned dur, acc;
		longint p, e;
		dur = (mdl_dur == 0) ? 1 : mdl_dur;
		acc = longint'(mdl_elapsed) + t.dt;
		if (acc > dur) acc = dur;
		mdl_elapsed = acc[31:0];
		p = longint'((longint'(mdl_elapsed) <<< FB) / dur);
		if (p > ONE_E) p = ONE_E;
		if (p == ONE_E) n_done++;
		e = eased(mdl_kind, p);
		for (int j = 0; j < NUM_PROPS; j++) f.prop[j] = lerp_clip(t.src[j], t.dst[j], e);
		f.lprog = p[16:0];
		frame_q.push_back(f);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_tick(cur_tick);
				n_ticks++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 0;
				end else if (tick_q.size() != 0) begin
					tick_t t;
					t = tick_q.pop_front();
					cur_tick <= t;
					delta_time_us <= t.dt;
					start_x <= t.src[0]; start_y <= t.src[1]; start_width <= t.src[2];
					start_height <= t.src[3]; start_rotation <= t.src[4];
					goal_x <= t.dst[0]; goal_y <= t.dst[1]; goal_width <= t.dst[2];
					goal_height <= t.dst[3]; goal_rotation <= t.dst[4];
					in_valid <= 1;
					in_gap <= rand_gap();
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (frame_q.size() == 0) begin
					n_err++;
					if (n_err <= 10) $display("unexpected output beat at %0t", $realtime);
				end else begin
					frame_t f;
					prop_t got [NUM_PROPS];
					bit bad;
					f = frame_q.pop_front();
					got = '{out_x, out_y, out_width, out_height, out_rotation};
					bad = (linear_progress !== f.lprog);
					for (int j = 0; j < NUM_PROPS; j++) if (got[j] !== f.prop[j]) bad = 1;
					for (int j = 0; j < NUM_PROPS; j++)
						if (f.prop[j] == 32'h7fffffff || f.prop[j] == 32'h80000000) n_sat++;
					if (bad) begin
						n_err++;
						if (n_err <= 10)
							$display("mismatch beat %0d: exp %h %h %h %h %h lp %h got %h %h %h %h %h lp %h",
								n_frames, f.prop[0], f.prop[1], f.prop[2], f.prop[3], f.prop[4],
								f.lprog, got[0], got[1], got[2], got[3], got[4], linear_progress);
					end
				end
				n_frames++;
			end
			if (out_gap != 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
				if (out_valid && out_ready) out_gap <= rand_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc <= 0;
		else idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= WD_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WD_LIMIT);
			$display("** eased_tween_interpolator: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		if (idx == REG_EASE_KIND) mdl_kind = val[1:0];
		else if (idx == REG_DURATION) mdl_dur = val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		while (tick_q.size() != 0 || in_valid || frame_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic prop_t rand_prop(int mode);
		case (mode)
			0: return prop_t'($urandom);
			1: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 255)
				: 32'h80000000 + $urandom_range(0, 255);
			default: return prop_t'($signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000);
		endcase
	endfunction

	task automatic add_tick(logic [19:0] dt, int mode);
		tick_t t;
		t.dt = dt;
		for (int j = 0; j < NUM_PROPS; j++) begin
			t.src[j] = rand_prop(mode == 3 ? $urandom_range(0, 2) : mode);
			t.dst[j] = rand_prop(mode == 3 ? $urandom_range(0, 2) : mode);
		end
		tick_q.push_back(t);
	endtask

	task automatic add_edge_tick(logic [19:0] dt, prop_t a, prop_t b);
		tick_t t;
		t.dt = dt;
		for (int j = 0; j < NUM_PROPS; j++) begin
			t.src[j] = a;
			t.dst[j] = b;
		end
		tick_q.push_back(t);
	endtask

	initial begin
		longint unsigned dur;
		int span, avg, cnt;
		logic [1:0] kind;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// reset values: linear over 1 s
		add_edge_tick(20'd0, 32'h80000000, 32'h7fffffff);
		add_edge_tick(20'hfffff, 32'h7fffffff, 32'h80000000);
		add_tick(20'd12345, 0);
		drain();
		// exponential to its end point, elastic from a third of its duration onward
		write_reg(REG_EASE_KIND, {30'd0, EASE_EXP});
		add_edge_tick(20'd0, 32'h80000000, 32'h7fffffff);
		add_edge_tick(20'hfffff, 32'h80000000, 32'h7fffffff);
		drain();
		write_reg(REG_DURATION, 32'd2000000 + mdl_elapsed);
		write_reg(REG_EASE_KIND, {30'd0, EASE_ELASTIC});
		add_edge_tick(20'd0, 32'h80000000, 32'h7fffffff);
		for (int i = 0; i < 6; i++) add_edge_tick(20'd40000, 32'h80000000, 32'h7fffffff);
		add_tick(20'hfffff, 1);
		drain();
		// shortened and zero duration, then unused kind and ignored indexes
		write_reg(REG_DURATION, 32'd0);
		add_tick(20'd1, 0);
		add_tick(20'd0, 1);
		drain();
		write_reg(REG_EASE_KIND, 32'd3);
		write_reg(REG_DURATION, 32'hffffffff);
		write_reg(2'd2, 32'd5);
		write_reg(2'd3, 32'h12345678);
		add_tick(20'h55555, 0);
		add_tick(20'haaaaa, 3);
		add_edge_tick(20'd7, 32'h0, 32'h0);
		drain();

		// random sweeps, most phases a fresh tween window above the kept time, phase 7 a duration below it
		for (int ph = 0; ph < 12; ph++) begin
			kind = $urandom_range(0, 3);
			if (ph % 4 == 0) kind = EASE_ELASTIC;
			if (ph % 4 == 1) kind = EASE_EXP;
			write_reg(REG_EASE_KIND, {30'd0, kind});
			cnt = 125;
			span = $urandom_range(0, 3) == 0 ? $urandom_range(200, 5000)
				: $urandom_range(5000, 60000000);
			avg = span / cnt + 1;
			if (avg > 20'hfffff / 2) avg = 20'hfffff / 2;
			dur = longint'(mdl_elapsed) + span;
			if (ph == 7) dur = mdl_elapsed / 2 + 1;
			if (ph == 11 || dur > 64'hffffffff) dur = 64'hffffffff;
			write_reg(REG_DURATION, dur[31:0]);
			for (int i = 0; i < cnt; i++) begin
				if ($urandom_range(0, 9) == 0) add_tick(20'($urandom), $urandom_range(0, 3));
				else add_tick(20'($urandom_range(0, 2 * avg)), $urandom_range(0, 3));
			end
			drain();
		end
		all_sent = 1;

		$display("covered %0d ticks, %0d checked beats over linear, exp, elastic and unused curves",
			n_ticks, n_frames);
		$display("%0d beats at full progress, %0d saturated properties, %0d mismatches",
			n_done, n_sat, n_err);
		if (n_err == 0 && frame_q.size() == 0)
			$display("** eased_tween_interpolator: PASSED **");
		else
			$display("** eased_tween_interpolator: FAILED **");
		$finish;
	end

endmodule
